### rtl/bresenham_line_rasterizer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line rasterizer
// Clocked on i_clk and switched off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define BRL_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/brl_pkg.sv
// ---------------------------------------------------------------------------
// brl_pkg
// Shared types, codes and constants of the line rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

    localparam int COORD_W   = 16;
    localparam int POS_W     = COORD_W + 1;   // positions, magnitudes of deltas
    localparam int ERR_W     = COORD_W + 3;   // error accumulator
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 24;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_FRAME_DIM_DEF = 4096;
    localparam int FRAME_WIDTH_RST   = 1920;
    localparam int FRAME_HEIGHT_RST  = 1080;

    // request codes
    localparam logic [1:0] REQ_LINE = 2'd0;
    localparam logic [1:0] REQ_TRI  = 2'd1;
    localparam logic [1:0] REQ_STEP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // {red, green, blue}
    localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [CHAN_W-1:0]         blue;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         red;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_index;
        logic              write_enable;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic              last_pixel;
    } t_res;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vtx;

    typedef struct packed {
        logic signed [POS_W-1:0] row;
        logic signed [POS_W-1:0] col;
        logic [COLOR_W-1:0]      color;
        logic                    last;
    } t_pix;

    // frame size register width: room for the saturation value and the reset sizes
    function automatic int dim_bits(input int max_dim);
        int w;
        w = $clog2(max_dim + 1);
        if (w < $clog2(FRAME_WIDTH_RST + 1)) begin
            w = $clog2(FRAME_WIDTH_RST + 1);
        end
        if (w > CFG_W) begin
            w = CFG_W;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/brl_cfg.sv
// ---------------------------------------------------------------------------
// brl_cfg
// Frame size registers with saturation, and the registered frame area.
// ---------------------------------------------------------------------------
`default_nettype none

module brl_cfg import brl_pkg::*; #(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF,
    localparam int DIM_W = dim_bits(MAX_FRAME_DIM),
    localparam int LIM_W = 2 * DIM_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [DIM_W-1:0]     o_frame_width,
    output logic [LIM_W-1:0]     o_limit
);

    logic [DIM_W-1:0] r_fw;
    logic [DIM_W-1:0] r_fh;
    logic [LIM_W-1:0] r_limit;
    logic [DIM_W-1:0] n_val;

    always_comb begin
        if (32'(i_cfg_data) > 32'(MAX_FRAME_DIM)) begin
            n_val = DIM_W'(MAX_FRAME_DIM);
        end else begin
            n_val = DIM_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= DIM_W'(FRAME_WIDTH_RST);
            r_fh    <= DIM_W'(FRAME_HEIGHT_RST);
            r_limit <= LIM_W'(FRAME_WIDTH_RST * FRAME_HEIGHT_RST);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_fw <= n_val;
                    CFG_FRAME_HEIGHT: r_fh <= n_val;
                    default: ;
                endcase
            end
            r_limit <= LIM_W'(r_fw) * LIM_W'(r_fh);
        end
    end

    assign o_frame_width = r_fw;
    assign o_limit       = r_limit;

endmodule

`default_nettype wire

### rtl/brl_step.sv
// ---------------------------------------------------------------------------
// brl_step
// Input register, triangle vertex sort, edge setup and the Bresenham step.
// Emits one row/column pair per step word while a line is active.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bresenham_line_rasterizer_top_assert.svh"

module brl_step import brl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_px_valid,
    output t_pix o_px,
    input  logic i_px_ready
);

    // edges still queued behind the current one
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_ONE  = 2'd1;
    localparam logic [1:0] EDGE_TWO  = 2'd2;

    logic en_in, en_px, fire;

    logic r_in_v;
    t_req r_in;

    logic                    r_busy, n_busy;
    logic                    r_steep, n_steep;
    logic signed [POS_W-1:0] r_maj_pos, n_maj_pos;
    logic signed [POS_W-1:0] r_maj_end, n_maj_end;
    logic signed [POS_W-1:0] r_min_pos, n_min_pos;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [POS_W-1:0]        r_dmaj, n_dmaj;
    logic [POS_W-1:0]        r_dmin, n_dmin;
    logic                    r_min_dir, n_min_dir;
    logic [COLOR_W-1:0]      r_color, n_color;
    logic [1:0]              r_edge, n_edge;
    t_vtx                    r_sv [3];
    logic                    sv_we;

    logic r_px_v;
    t_pix r_px;
    t_pix px_next;
    logic px_gen;

    // sorted triangle vertices
    t_vtx s0, s1, s2, stmp;

    // edge setup
    logic                      ld_en;
    t_vtx                      ld_a, ld_b;
    logic [COLOR_W-1:0]        ld_color;
    logic signed [POS_W-1:0]   dx, dy;
    logic [POS_W-1:0]          adx, ady;
    logic                      e_steep;
    logic signed [COORD_W-1:0] p0, q0, p1, q1, ps, pe, qs, qf;

    // step
    logic                    done;
    logic signed [ERR_W-1:0] err_sum;
    logic signed [ERR_W:0]   err_dbl;
    logic                    err_ge;

    assign en_px   = !r_px_v || i_px_ready;
    assign en_in   = !r_in_v || en_px;
    assign fire    = r_in_v && en_px;
    assign o_stall = !en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en_in) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in <= i_req;
        end
    end

    // sort by y, three compare-and-swap passes
    always_comb begin
        s0.x = r_in.ax;
        s0.y = r_in.ay;
        s1.x = r_in.bx;
        s1.y = r_in.by_coord;
        s2.x = r_in.cx;
        s2.y = r_in.cy;
        stmp = s0;
        if (s0.y > s1.y) begin
            stmp = s0;
            s0   = s1;
            s1   = stmp;
        end
        if (s0.y > s2.y) begin
            stmp = s0;
            s0   = s2;
            s2   = stmp;
        end
        if (s1.y > s2.y) begin
            stmp = s1;
            s1   = s2;
            s2   = stmp;
        end
    end

    // edge setup: major axis is the longer one, x on ties; walk low to high
    always_comb begin
        dx      = POS_W'(ld_b.x) - POS_W'(ld_a.x);
        dy      = POS_W'(ld_b.y) - POS_W'(ld_a.y);
        adx     = dx[POS_W-1] ? POS_W'(-dx) : POS_W'(dx);
        ady     = dy[POS_W-1] ? POS_W'(-dy) : POS_W'(dy);
        e_steep = ady > adx;
        p0      = e_steep ? ld_a.y : ld_a.x;
        q0      = e_steep ? ld_a.x : ld_a.y;
        p1      = e_steep ? ld_b.y : ld_b.x;
        q1      = e_steep ? ld_b.x : ld_b.y;
        if (p1 < p0) begin
            ps = p1;
            pe = p0;
            qs = q1;
            qf = q0;
        end else begin
            ps = p0;
            pe = p1;
            qs = q0;
            qf = q1;
        end
    end

    assign done    = r_maj_pos >= r_maj_end;
    assign err_sum = r_err + ERR_W'($signed({1'b0, r_dmin}));
    assign err_dbl = $signed({err_sum, 1'b0});
    assign err_ge  = err_dbl >= $signed((ERR_W + 1)'({1'b0, r_dmaj}));

    always_comb begin
        n_busy    = r_busy;
        n_steep   = r_steep;
        n_maj_pos = r_maj_pos;
        n_maj_end = r_maj_end;
        n_min_pos = r_min_pos;
        n_err     = r_err;
        n_dmaj    = r_dmaj;
        n_dmin    = r_dmin;
        n_min_dir = r_min_dir;
        n_color   = r_color;
        n_edge    = r_edge;
        sv_we     = 1'b0;
        ld_en     = 1'b0;
        ld_a      = s0;
        ld_b      = s1;
        ld_color  = COLOR_GREEN;
        px_gen    = 1'b0;
        px_next.row   = r_steep ? r_maj_pos : r_min_pos;
        px_next.col   = r_steep ? r_min_pos : r_maj_pos;
        px_next.color = r_color;
        px_next.last  = 1'b0;

        if (fire) begin
            unique case (r_in.req_type)
                REQ_LINE: begin
                    ld_en    = 1'b1;
                    ld_a.x   = r_in.ax;
                    ld_a.y   = r_in.ay;
                    ld_b.x   = r_in.bx;
                    ld_b.y   = r_in.by_coord;
                    ld_color = {r_in.red, r_in.green, r_in.blue};
                    n_edge   = EDGE_NONE;
                end
                REQ_TRI: begin
                    ld_en  = 1'b1;
                    sv_we  = 1'b1;
                    n_edge = EDGE_TWO;
                end
                REQ_STEP: begin
                    if (r_busy) begin
                        px_gen    = 1'b1;
                        n_maj_pos = r_maj_pos + POS_W'(1);
                        if (err_ge) begin
                            n_min_pos = r_min_dir ? r_min_pos + POS_W'(1)
                                                  : r_min_pos - POS_W'(1);
                            n_err     = err_sum - ERR_W'($signed({1'b0, r_dmaj}));
                        end else begin
                            n_err = err_sum;
                        end
                        if (done) begin
                            if (r_edge == EDGE_TWO) begin
                                ld_en  = 1'b1;
                                ld_a   = r_sv[1];
                                ld_b   = r_sv[2];
                                n_edge = EDGE_ONE;
                            end else if (r_edge == EDGE_ONE) begin
                                ld_en    = 1'b1;
                                ld_a     = r_sv[2];
                                ld_b     = r_sv[0];
                                ld_color = COLOR_RED;
                                n_edge   = EDGE_NONE;
                            end else begin
                                n_busy       = 1'b0;
                                px_next.last = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (ld_en) begin
            n_busy    = 1'b1;
            n_steep   = e_steep;
            n_maj_pos = POS_W'(ps);
            n_maj_end = POS_W'(pe);
            n_min_pos = POS_W'(qs);
            n_err     = '0;
            n_dmaj    = e_steep ? ady : adx;
            n_dmin    = e_steep ? adx : ady;
            n_min_dir = qs < qf;
            n_color   = ld_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_steep   <= 1'b0;
            r_maj_pos <= '0;
            r_maj_end <= '0;
            r_min_pos <= '0;
            r_err     <= '0;
            r_dmaj    <= '0;
            r_dmin    <= '0;
            r_min_dir <= 1'b0;
            r_color   <= '0;
            r_edge    <= EDGE_NONE;
        end else begin
            r_busy    <= n_busy;
            r_steep   <= n_steep;
            r_maj_pos <= n_maj_pos;
            r_maj_end <= n_maj_end;
            r_min_pos <= n_min_pos;
            r_err     <= n_err;
            r_dmaj    <= n_dmaj;
            r_dmin    <= n_dmin;
            r_min_dir <= n_min_dir;
            r_color   <= n_color;
            r_edge    <= n_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sv_we) begin
            r_sv[0] <= s0;
            r_sv[1] <= s1;
            r_sv[2] <= s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_v <= 1'b0;
        end else if (en_px) begin
            r_px_v <= px_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_px && px_gen) begin
            r_px <= px_next;
        end
    end

    assign o_px_valid = r_px_v;
    assign o_px       = r_px;

    `BRL_ASSERT_HOLDS(a_queue_busy, r_edge != EDGE_NONE, r_busy,
        "edges queued while rasterizer idle")
    `BRL_ASSERT_HOLDS(a_last_idle, r_px_v && r_px.last, !r_busy,
        "still busy after final pixel")
    `BRL_ASSERT_NEXT(a_step_px, fire && (r_in.req_type == REQ_STEP), r_px_v == $past(r_busy),
        "step word produced wrong pixel count")

endmodule

`default_nettype wire

### rtl/brl_idx.sv
// ---------------------------------------------------------------------------
// brl_idx
// Linear index row * width + column, frame bounds check, result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bresenham_line_rasterizer_top_assert.svh"

module brl_idx import brl_pkg::*; #(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF,
    localparam int DIM_W  = dim_bits(MAX_FRAME_DIM),
    localparam int LIM_W  = 2 * DIM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_px_valid,
    input  t_pix             i_px,
    output logic             o_px_ready,
    input  logic [DIM_W-1:0] i_frame_width,
    input  logic [LIM_W-1:0] i_limit,
    output logic             o_valid,
    output t_res             o_res,
    input  logic             i_stall
);

    localparam int PROD_W = POS_W + DIM_W + 1;
    localparam int IDX_W  = PROD_W + 1;

    logic en_out, en_prod;

    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [POS_W-1:0]  r_col;
    logic [COLOR_W-1:0]       r_color;
    logic                     r_last;

    logic signed [IDX_W-1:0]  idx;
    logic                     in_frame;
    t_res                     n_res;

    logic r_out_v;
    t_res r_out;

    assign en_out     = !r_out_v || !i_stall;
    assign en_prod    = !r_prod_v || en_out;
    assign o_px_ready = en_prod;

    assign n_prod = PROD_W'(i_px.row) * PROD_W'($signed({1'b0, i_frame_width}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else if (en_prod) begin
            r_prod_v <= i_px_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_prod && i_px_valid) begin
            r_prod  <= n_prod;
            r_col   <= i_px.col;
            r_color <= i_px.color;
            r_last  <= i_px.last;
        end
    end

    assign idx      = IDX_W'(r_prod) + IDX_W'(r_col);
    assign in_frame = !idx[IDX_W-1] && ($unsigned(idx) < IDX_W'(i_limit));

    always_comb begin
        n_res.pixel_index  = idx[PIX_W-1:0];
        n_res.write_enable = in_frame;
        n_res.out_blue     = r_color[CHAN_W-1:0];
        n_res.out_green    = r_color[2*CHAN_W-1:CHAN_W];
        n_res.out_red      = r_color[3*CHAN_W-1:2*CHAN_W];
        n_res.last_pixel   = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_prod_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_prod_v) begin
            r_out <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

    `BRL_ASSERT_NEXT(a_prod_hold, r_prod_v && !en_out, r_prod_v && $stable(r_prod),
        "product stage lost or changed a held word")
    `BRL_ASSERT_HOLDS(a_out_src, $rose(r_out_v), $past(r_prod_v),
        "result appeared without a product")
    `BRL_ASSERT_NEXT(a_out_hold, r_out_v && i_stall, r_out_v && $stable(r_out),
        "stalled result word changed")

endmodule

`default_nettype wire

### rtl/bresenham_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Path: a step word's pixel passes the input, pixel and product registers and the
//   result register to o_valid; the Bresenham update is combinational.
// Throughput: 1 word per cycle unless stalled, 1 pixel per step word while a line is active.
// Reset: synchronous, active-low; clears all valids and line state, frame size 1920 x 1080.
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_top import brl_pkg::*; #(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_req                 i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DIM_W = dim_bits(MAX_FRAME_DIM);
    localparam int LIM_W = 2 * DIM_W;

    logic [DIM_W-1:0] frame_width;
    logic [LIM_W-1:0] limit;
    logic             px_valid;
    t_pix             px;
    logic             px_ready;

    brl_cfg #(
        .MAX_FRAME_DIM(MAX_FRAME_DIM)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_frame_width (frame_width),
        .o_limit       (limit)
    );

    brl_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req      (i_req),
        .o_stall    (o_stall),
        .o_px_valid (px_valid),
        .o_px       (px),
        .i_px_ready (px_ready)
    );

    brl_idx #(
        .MAX_FRAME_DIM(MAX_FRAME_DIM)
    ) u_idx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px_valid    (px_valid),
        .i_px          (px),
        .o_px_ready    (px_ready),
        .i_frame_width (frame_width),
        .i_limit       (limit),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .i_stall       (i_stall)
    );

endmodule

`default_nettype wire
